@@ design/cssev_pkg.sv @@
// cssev_pkg: shared types, constants and the arctangent table for the cosine series evaluator
// used by cssev_front, cssev_basis, cssev_back and the top level; no other dependencies
`timescale 1ns / 1ps

package cssev_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int STEP_W       = 5;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
    localparam int N_W          = 6;
    localparam int D1_SCALE     = 164710;
    localparam int D2_SCALE     = 413961;
    localparam int DIV5_RECIP   = 838861;
    localparam int ACC_W        = 96;
    localparam int OUT_W        = 48;
    localparam int S_TDATA_W    = 80;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_EVAL,
        CMD_ZERO
    } cmd_kind_t;

    typedef enum logic [1:0] {
        DERIV_VALUE = 2'd0,
        DERIV_SLOPE = 2'd1,
        DERIV_CURVE = 2'd2
    } deriv_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [3:0]         order_u;
        logic [3:0]         order_v;
        logic [1:0]         component;
        logic signed [31:0] coeff_value;
        logic [15:0]        pos_u;
        logic [15:0]        pos_v;
        deriv_t             deriv_u;
        deriv_t             deriv_v;
    } cmd_t;

    typedef struct packed {
        logic           start;
        logic [N_W-1:0] n;
        deriv_t         d;
        logic [15:0]    pos;
    } basis_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] value;
    } basis_rsp_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_PREP,
        BS_FOLD,
        BS_ITER,
        BS_MUL,
        BS_FIN
    } basis_state_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_WRITE,
        BK_BREQ,
        BK_BWAIT,
        BK_MAC,
        BK_DRAIN,
        BK_ROUND,
        BK_OUT
    } back_state_t;

    // arctangent of 2^-i in units of 2^32 per turn
    function automatic logic [29:0] atan_at(input logic [STEP_W-1:0] i);
        logic [29:0] r;
        unique case (i)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

@@ design/cssev_front.sv @@
// cssev_front: input stage, classifies each item and holds a two-entry command queue
// depends on cssev_pkg
`timescale 1ns / 1ps

module cssev_front #(
    parameter int BASES_U    = 16,
    parameter int BASES_V    = 16,
    parameter int COMPONENTS = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cssev_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]                     s_tuser,
    input  logic                           clearing,
    output logic                           cmd_valid,
    output cssev_pkg::cmd_t                cmd,
    input  logic                           cmd_pop
);
    import cssev_pkg::*;

    cmd_t       q_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg, count_next;
    cmd_t       item;
    logic       in_range, keep, push;

    // clamp derivative orders of three to the second derivative
    function automatic deriv_t clamp_d(input logic [1:0] d);
        deriv_t r;
        priority if (d >= 2'd2) r = DERIV_CURVE;
        else if (d == 2'd1)     r = DERIV_SLOPE;
        else                    r = DERIV_VALUE;
        return r;
    endfunction

    always_comb begin
        item.order_u     = s_tdata[3:0];
        item.order_v     = s_tdata[7:4];
        item.component   = s_tdata[9:8];
        item.coeff_value = s_tdata[41:10];
        item.pos_u       = s_tdata[57:42];
        item.pos_v       = s_tdata[73:58];
        item.deriv_u     = clamp_d(s_tdata[75:74]);
        item.deriv_v     = clamp_d(s_tdata[77:76]);
        in_range = (32'(s_tdata[3:0]) < BASES_U) && (32'(s_tdata[7:4]) < BASES_V)
                   && (32'(s_tdata[9:8]) < COMPONENTS);
        // out-of-range writes are taken and dropped here
        keep = 1'b1;
        if (!s_tuser[0]) begin
            item.kind = CMD_WRITE;
            keep      = in_range;
        end else if (32'(s_tdata[9:8]) < COMPONENTS) begin
            item.kind = CMD_EVAL;
        end else begin
            item.kind = CMD_ZERO;
        end
    end

    assign s_tready  = (count_reg != 2'd2) && !clearing;
    assign push      = s_tvalid && s_tready && keep;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !cmd_pop)      count_next = count_reg + 2'd1;
        else if (!push && cmd_pop) count_next = count_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push)    wptr_reg <= ~wptr_reg;
            if (cmd_pop) rptr_reg <= ~rptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wptr_reg] <= item;
    end

endmodule

@@ design/cssev_basis.sv @@
// cssev_basis: one cosine basis value per request, iterative 20-step rotation cordic
// depends on cssev_pkg
`timescale 1ns / 1ps

module cssev_basis (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cssev_pkg::basis_req_t   req,
    output cssev_pkg::basis_rsp_t   rsp
);
    import cssev_pkg::*;

    basis_state_t       state_reg, state_next;
    logic [N_W-1:0]     n_reg;
    deriv_t             d_reg;
    logic [15:0]        pos_reg;
    logic [15:0]        s_reg;
    logic [11:0]        nn_reg;
    logic [30:0]        k_reg;
    logic signed [33:0] x_reg, y_reg, c_reg;
    logic signed [32:0] z_reg;
    logic               flip_reg;
    logic [STEP_W-1:0]  step_reg;
    logic signed [65:0] prod_reg;

    logic [18:0]        num;
    logic [38:0]        quot;
    logic [21:0]        nphase;
    logic [31:0]        angle, folded;
    logic               flip;
    logic signed [33:0] dx, dy, cs, sn;
    logic signed [32:0] at;
    logic signed [33:0] rnd0;
    logic signed [65:0] rnd1;

    always_comb begin
        // s = round((4 pos + 32768) / 5) via reciprocal multiply
        num    = {1'b0, pos_reg, 2'b00} + 19'd32770;
        quot   = 39'(num) * 39'(DIV5_RECIP);
        nphase = 22'(n_reg) * 22'(s_reg);
        angle  = {nphase[16:0], 15'd0};
        flip   = angle[31] ^ angle[30];
        folded = flip ? angle + 32'h8000_0000 : angle;
        dx     = y_reg >>> step_reg;
        dy     = x_reg >>> step_reg;
        at     = $signed({3'b000, atan_at(step_reg)});
        cs     = flip_reg ? -x_reg : x_reg;
        sn     = flip_reg ? -y_reg : y_reg;
        rnd0   = (c_reg + 34'sd8192) >>> 14;
        rnd1   = (prod_reg + 66'sd536870912) >>> 30;
    end

    always_comb begin
        state_next = state_reg;
        rsp.done   = 1'b0;
        rsp.value  = (d_reg == DERIV_VALUE) ? rnd0[31:0] : -rnd1[31:0];
        unique case (state_reg)
            BS_IDLE: if (req.start) state_next = BS_PREP;
            BS_PREP: state_next = BS_FOLD;
            BS_FOLD: state_next = BS_ITER;
            BS_ITER: if (step_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = BS_MUL;
            BS_MUL:  state_next = BS_FIN;
            BS_FIN: begin
                rsp.done   = 1'b1;
                state_next = BS_IDLE;
            end
            default: state_next = BS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= BS_IDLE;
        else          state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            BS_IDLE: begin
                n_reg   <= req.n;
                d_reg   <= req.d;
                pos_reg <= req.pos;
            end
            BS_PREP: begin
                s_reg  <= quot[37:22];
                nn_reg <= 12'(n_reg) * 12'(n_reg);
            end
            BS_FOLD: begin
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                z_reg    <= $signed({folded[31], folded});
                flip_reg <= flip;
                step_reg <= '0;
                k_reg    <= (d_reg == DERIV_SLOPE) ? 31'(D1_SCALE) * 31'(n_reg)
                                                   : 31'(D2_SCALE) * 31'(nn_reg);
            end
            BS_ITER: begin
                if (!z_reg[32]) begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                step_reg <= step_reg + STEP_W'(1);
            end
            BS_MUL: begin
                c_reg    <= cs;
                prod_reg <= $signed({1'b0, k_reg}) * ((d_reg == DERIV_SLOPE) ? sn : cs);
            end
            default: ;
        endcase
    end

endmodule

@@ design/cssev_back.sv @@
// cssev_back: coefficient store, basis tables, multiply-accumulate pipeline and result register
// depends on cssev_pkg and cssev_basis
`timescale 1ns / 1ps

module cssev_back #(
    parameter int BASES_U    = 16,
    parameter int BASES_V    = 16,
    parameter int COMPONENTS = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_valid,
    input  cssev_pkg::cmd_t             cmd,
    output logic                        cmd_pop,
    output logic                        clearing,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cssev_pkg::OUT_W-1:0] m_tdata
);
    import cssev_pkg::*;

    localparam int DEPTH = BASES_U * BASES_V * COMPONENTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int UW    = (BASES_U > 1) ? $clog2(BASES_U) : 1;
    localparam int VW    = (BASES_V > 1) ? $clog2(BASES_V) : 1;
    localparam int TW    = $clog2(BASES_U + BASES_V);
    localparam int PAIRS = BASES_U * BASES_V;
    localparam int PW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg;
    logic [AW-1:0]      clr_reg;
    logic [TW-1:0]      bcnt_reg;
    logic [PW-1:0]      pair_reg;
    logic [UW-1:0]      i_reg;
    logic [VW-1:0]      j_reg;
    logic [4:0]         v_reg;
    logic               m_valid_reg;
    logic [OUT_W-1:0]   m_data_reg;

    logic [31:0]        store_mem [DEPTH];
    logic signed [31:0] bu_mem [BASES_U];
    logic signed [31:0] bv_mem [BASES_V];
    logic signed [31:0] cf_q, bu_q, bv_q;

    logic signed [63:0]    p_reg;
    logic signed [31:0]    c1_reg, c2_reg;
    logic signed [47:0]    w_reg;
    logic signed [56:0]    pl_reg;
    logic signed [55:0]    ph_reg;
    logic signed [ACC_W-1:0] term_reg, acc_reg;

    basis_req_t         breq;
    basis_rsp_t         brsp;
    logic               b_start;
    logic               st_we, mac_issue, out_load, u_side;
    logic [AW-1:0]      st_waddr, rd_addr;
    logic [31:0]        st_wdata;
    logic [TW-1:0]      vidx;
    logic signed [63:0] w_full;
    logic signed [ACC_W-17:0] rounded;
    logic [OUT_W-1:0]   sat;

    cssev_basis u_basis (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (breq),
        .rsp     (brsp)
    );

    always_comb begin
        u_side     = (32'(bcnt_reg) < BASES_U);
        vidx       = bcnt_reg - TW'(BASES_U);
        breq.start = b_start;
        breq.n     = u_side ? N_W'(bcnt_reg) : N_W'(vidx);
        breq.d     = u_side ? cmd_reg.deriv_u : cmd_reg.deriv_v;
        breq.pos   = u_side ? cmd_reg.pos_u : cmd_reg.pos_v;
        st_waddr = clearing ? clr_reg
                 : AW'((32'(cmd_reg.order_u) * BASES_V + 32'(cmd_reg.order_v)) * COMPONENTS
                       + 32'(cmd_reg.component));
        st_wdata = clearing ? 32'd0 : cmd_reg.coeff_value;
        rd_addr  = AW'(32'(pair_reg) * COMPONENTS + 32'(cmd_reg.component));
        w_full   = (p_reg + 64'sd32768) >>> 16;
        rounded  = acc_reg[ACC_W-1:16];
        // saturate to the 48-bit signed range
        if (!rounded[ACC_W-17] && (|rounded[ACC_W-17:OUT_W-1]))
            sat = {1'b0, {(OUT_W-1){1'b1}}};
        else if (rounded[ACC_W-17] && !(&rounded[ACC_W-17:OUT_W-1]))
            sat = {1'b1, {(OUT_W-1){1'b0}}};
        else
            sat = rounded[OUT_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        clearing   = 1'b0;
        st_we      = 1'b0;
        b_start    = 1'b0;
        mac_issue  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            BK_CLEAR: begin
                clearing = 1'b1;
                st_we    = 1'b1;
                if (32'(clr_reg) == DEPTH - 1) state_next = BK_IDLE;
            end
            BK_IDLE: if (cmd_valid) begin
                cmd_pop = 1'b1;
                unique case (cmd.kind)
                    CMD_WRITE: state_next = BK_WRITE;
                    CMD_EVAL:  state_next = BK_BREQ;
                    default:   state_next = BK_ROUND;
                endcase
            end
            BK_WRITE: begin
                st_we      = 1'b1;
                state_next = BK_IDLE;
            end
            BK_BREQ: begin
                b_start    = 1'b1;
                state_next = BK_BWAIT;
            end
            BK_BWAIT: if (brsp.done) begin
                if (32'(bcnt_reg) == BASES_U + BASES_V - 1) state_next = BK_MAC;
                else                                        state_next = BK_BREQ;
            end
            BK_MAC: begin
                mac_issue = 1'b1;
                if (32'(pair_reg) == PAIRS - 1) state_next = BK_DRAIN;
            end
            BK_DRAIN: if (v_reg == 5'd0) state_next = BK_ROUND;
            BK_ROUND: state_next = BK_OUT;
            BK_OUT: if (!m_valid_reg || m_tready) begin
                out_load   = 1'b1;
                state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_CLEAR;
            clr_reg     <= '0;
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clearing) clr_reg <= clr_reg + AW'(1);
            v_reg <= {v_reg[3:0], mac_issue};
            if (out_load)      m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    // sequencer datapath
    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            cmd_reg  <= cmd;
            bcnt_reg <= '0;
            pair_reg <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
        end
        if (state_reg == BK_BWAIT && brsp.done) bcnt_reg <= bcnt_reg + TW'(1);
        if (mac_issue) begin
            pair_reg <= pair_reg + PW'(1);
            if (32'(j_reg) == BASES_V - 1) begin
                j_reg <= '0;
                i_reg <= i_reg + UW'(1);
            end else begin
                j_reg <= j_reg + VW'(1);
            end
        end
        if (out_load) m_data_reg <= sat;
    end

    // memories
    always_ff @(posedge aclk) begin
        if (st_we) store_mem[st_waddr] <= st_wdata;
        cf_q <= store_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == BK_BWAIT && brsp.done && u_side) bu_mem[UW'(bcnt_reg)] <= brsp.value;
        bu_q <= bu_mem[i_reg];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == BK_BWAIT && brsp.done && !u_side) bv_mem[VW'(vidx)] <= brsp.value;
        bv_q <= bv_mem[j_reg];
    end

    // multiply-accumulate pipeline
    always_ff @(posedge aclk) begin
        p_reg    <= bu_q * bv_q;
        c1_reg   <= cf_q;
        w_reg    <= w_full[47:0];
        c2_reg   <= c1_reg;
        pl_reg   <= c2_reg * $signed({1'b0, w_reg[23:0]});
        ph_reg   <= c2_reg * $signed(w_reg[47:24]);
        term_reg <= (ACC_W'(ph_reg) <<< 24) + ACC_W'(pl_reg);
        if (cmd_pop)         acc_reg <= '0;
        else if (v_reg[4])   acc_reg <= acc_reg + term_reg;
        else if (state_reg == BK_ROUND) acc_reg <= acc_reg + ACC_W'(32768);
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ design/cosine_series_surface_eval.sv @@
// cosine_series_surface_eval: top level of the two-dimensional cosine series evaluator
// depends on cssev_pkg, cssev_front, cssev_back (and cssev_basis below it)
`timescale 1ns / 1ps

//  channel   dir  handshake           payload
//  s_        in   s_tvalid/s_tready   s_tdata 80 bits, s_tuser 1 bit (opcode)
//  m_        out  m_tvalid/m_tready   m_tdata 48 bits (surface_value)
//
// a write item is popped and then written into the store by the back end;
// an evaluation first computes the BASES_U+BASES_V basis values one at a time
// on the shared iterative cordic and then forms one coefficient product per cycle
// from the store's single read port
// after reset a clearing pass zeroes every entry of the store;
// s_tready stays low during it
// a two-entry queue lets items in while the back end works or a result waits

module cosine_series_surface_eval #(
    parameter int BASES_U    = 16,
    parameter int BASES_V    = 16,
    parameter int COMPONENTS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // order_u[3:0], order_v[7:4], component[9:8], coeff_value[41:10],
    // pos_u[57:42], pos_v[73:58], deriv_u[75:74], deriv_v[77:76], zero fill
    input  logic [79:0] s_tdata,
    // opcode[0]: 0 write coefficient, 1 evaluate
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // surface_value[47:0], signed q32.16
    output logic [47:0] m_tdata
);
    import cssev_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_pop, clearing;

    // front end: classify items, drop out-of-range writes, queue the rest
    cssev_front #(
        .BASES_U    (BASES_U),
        .BASES_V    (BASES_V),
        .COMPONENTS (COMPONENTS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .clearing  (clearing),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // back end: store writes, basis generation, accumulation, saturation
    cssev_back #(
        .BASES_U    (BASES_U),
        .BASES_V    (BASES_V),
        .COMPONENTS (COMPONENTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .clearing  (clearing),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ dv/cosine_series_surface_eval_test.sv @@
// cosine_series_surface_eval_test: self-checking bench for the cosine series surface evaluator
// depends on cosine_series_surface_eval (and its package); carries its own fixed-point surface predictor
`timescale 1ns / 1ps

module cosine_series_surface_eval_test;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;
    localparam int   N_ITEMS  = 500;
    localparam int   QUIET_TAIL = 60;      // last items go through with no idling
    localparam int   WATCHDOG_LIMIT = 20000;
    localparam int   HOLD_OFF_CYCLES = 3000;

    typedef struct {
        logic               op;
        logic [3:0]         ou;
        logic [3:0]         ov;
        logic [1:0]         comp;
        logic signed [31:0] coeff;
        logic [15:0]        pu;
        logic [15:0]        pv;
        logic [1:0]         du;
        logic [1:0]         dv;
    } surf_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    cosine_series_surface_eval uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor: shadow coefficient store and fixed-point surface sum
    // ---------------------------------------------------------------
    logic signed [31:0] shadow_coeffs [16][16][4];
    logic [47:0]        surface_due [$];
    surf_item_t         items_pending [$];
    int                 failures = 0;
    int                 items_sent = 0;
    int                 results_seen = 0;

    // arctangent steps, 2^32 per turn
    localparam longint ATAN_TURNS [20] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087,
        667544, 333772, 166886, 83443, 41722,
        20861, 10430, 5215, 2608, 1304
    };

    function automatic longint rnd_shift(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    // rotation cordic in q2.30, angle folded into the right half-plane first
    function automatic void rotate_q30(input logic [31:0] angle,
                                       output longint cs, output longint sn);
        logic   flip;
        longint x, y, z, dx, dy;
        logic [31:0] a;
        a = angle;
        flip = 1'b0;
        x = 652032875;
        y = 0;
        if (((a + 32'h4000_0000) & 32'h8000_0000) != 0) begin
            a = a + 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'(signed'(a));
        for (int i = 0; i < 20; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_TURNS[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ATAN_TURNS[i];
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    // one basis value in q.16 for order n, derivative d, position pos
    function automatic longint basis_val(int n, logic [1:0] d, logic [15:0] pos);
        logic [31:0] s, phase;
        longint      cs, sn;
        s = (32'd4 * pos + 32'd32770) / 32'd5;
        phase = (32'(n) * s) << 15;
        rotate_q30(phase, cs, sn);
        if (d == 2'd0)
            return rnd_shift(cs, 14);
        if (d == 2'd1)
            return -rnd_shift(longint'(164710) * n * sn, 30);
        return -rnd_shift(longint'(413961) * n * n * cs, 30);
    endfunction

    function automatic logic [47:0] surface_sum(surf_item_t it);
        longint bu [16];
        longint bv [16];
        logic signed [127:0] acc;
        logic signed [127:0] q;
        longint w;
        acc = '0;
        for (int i = 0; i < 16; i++) begin
            bu[i] = basis_val(i, it.du, it.pu);
            bv[i] = basis_val(i, it.dv, it.pv);
        end
        for (int i = 0; i < 16; i++)
            for (int j = 0; j < 16; j++) begin
                w = rnd_shift(bu[i] * bv[j], 16);
                acc = acc + 128'(shadow_coeffs[i][j][it.comp]) * 128'(w);
            end
        q = (acc + 128'sd32768) >>> 16;
        // saturate to q32.16
        if (q > 128'sh7FFF_FFFF_FFFF)
            return 48'h7FFF_FFFF_FFFF;
        if (q < -128'sh8000_0000_0000)
            return 48'h8000_0000_0000;
        return q[47:0];
    endfunction

    // applies an accepted item: writes update the shadow store, evaluations queue a result
    task automatic apply_item(surf_item_t it);
        if (it.op == OP_WRITE)
            shadow_coeffs[it.ou][it.ov][it.comp] = it.coeff;
        else
            surface_due.push_back(surface_sum(it));
    endtask

    // ---------------------------------------------------------------
    // stimulus builders
    // ---------------------------------------------------------------
    function automatic surf_item_t mk_write(int ou, int ov, int comp, logic [31:0] c);
        surf_item_t it;
        it.op = OP_WRITE; it.ou = 4'(ou); it.ov = 4'(ov); it.comp = 2'(comp); it.coeff = c;
        it.pu = 16'($urandom); it.pv = 16'($urandom);
        it.du = 2'($urandom); it.dv = 2'($urandom);
        return it;
    endfunction

    function automatic surf_item_t mk_eval(int comp, logic [15:0] pu, logic [15:0] pv,
                                           logic [1:0] du, logic [1:0] dv);
        surf_item_t it;
        it.op = OP_EVAL; it.comp = 2'(comp); it.pu = pu; it.pv = pv; it.du = du; it.dv = dv;
        it.ou = 4'($urandom); it.ov = 4'($urandom); it.coeff = $urandom;
        return it;
    endfunction

    function automatic logic [31:0] rand_coeff();
        // moderate values half the time, full-range or extreme ones otherwise to push saturation
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'(signed'($urandom_range(0, 2 ** 21)) - 2 ** 20);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // driver: offers pending items with random idle bursts
    // ---------------------------------------------------------------
    int idle_left = 0;

    always @(posedge aclk) begin
        surf_item_t it;
        logic       nv;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            nv = s_tvalid;
            if (s_tvalid && s_tready) begin
                nv = 1'b0;
            end
            if (!nv) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (items_pending.size() > 0) begin
                    it = items_pending.pop_front();
                    apply_item(it);   // block handles items strictly in order
                    s_tdata <= {2'b00, it.dv, it.du, it.pv, it.pu, it.coeff,
                                it.comp, it.ov, it.ou};
                    s_tuser <= it.op;
                    items_sent++;
                    nv = 1'b1;
                    if (items_sent < N_ITEMS - QUIET_TAIL && $urandom_range(0, 5) == 0)
                        idle_left = $urandom_range(1, 14);
                end
            end
            s_tvalid <= nv;
        end
    end

    // ---------------------------------------------------------------
    // receiver ready: random stalls plus one long hold-off
    // ---------------------------------------------------------------
    int  stall_left = 0;
    bit  held_once = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!held_once && results_seen == 5) begin
            // long hold so the input queue fills and s_tready drops
            held_once = 1;
            stall_left = HOLD_OFF_CYCLES;
            m_tready <= 1'b0;
        end else if (items_sent < N_ITEMS - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // monitor: compare each result with the oldest expected value
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        logic [47:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (surface_due.size() == 0) begin
                $error("surface_value: no result expected, actual %h", m_tdata);
                failures++;
            end else begin
                want = surface_due.pop_front();
                if (m_tdata !== want) begin
                    $error("surface_value: expected %h actual %h", want, m_tdata);
                    failures++;
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("cosine_series_surface_eval_test: FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial begin
        int cu, cv;
        for (int i = 0; i < 16; i++)
            for (int j = 0; j < 16; j++)
                for (int c = 0; c < 4; c++)
                    shadow_coeffs[i][j][c] = '0;

        // directed: empty store, corners, extremes, every derivative code
        items_pending.push_back(mk_eval(0, 16'h0000, 16'h0000, 2'd0, 2'd0));
        items_pending.push_back(mk_write(0, 0, 0, 32'h0001_0000));
        items_pending.push_back(mk_write(15, 15, 0, 32'h7FFF_FFFF));
        items_pending.push_back(mk_write(15, 0, 1, 32'h8000_0000));
        items_pending.push_back(mk_write(0, 15, 2, 32'hFFFF_FFFF));
        items_pending.push_back(mk_write(7, 9, 3, 32'h0000_0001));
        items_pending.push_back(mk_eval(0, 16'h0000, 16'hFFFF, 2'd0, 2'd0));
        items_pending.push_back(mk_eval(0, 16'hFFFF, 16'h0000, 2'd1, 2'd1));
        items_pending.push_back(mk_eval(0, 16'h0000, 16'h0000, 2'd2, 2'd2));   // saturates high
        items_pending.push_back(mk_eval(0, 16'h8000, 16'h4000, 2'd3, 2'd3));   // third acts as second
        items_pending.push_back(mk_eval(1, 16'h0000, 16'h0000, 2'd2, 2'd0));
        items_pending.push_back(mk_eval(1, 16'hFFFF, 16'hFFFF, 2'd2, 2'd3));
        items_pending.push_back(mk_eval(2, 16'h1234, 16'hFEDC, 2'd1, 2'd2));
        items_pending.push_back(mk_eval(3, 16'hAAAA, 16'h5555, 2'd0, 2'd1));
        items_pending.push_back(mk_write(15, 15, 0, 32'h8000_0000));
        items_pending.push_back(mk_write(15, 14, 0, 32'h8000_0000));
        items_pending.push_back(mk_eval(0, 16'h0000, 16'h0000, 2'd2, 2'd2));   // saturates low
        items_pending.push_back(mk_eval(0, 16'h7FFF, 16'h8001, 2'd1, 2'd0));

        // random: bursts of writes, mostly into a small corner of the store, each followed by an evaluation
        while (items_pending.size() < N_ITEMS) begin
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 3) == 0) begin
                    cu = $urandom_range(0, 15); cv = $urandom_range(0, 15);
                end else begin
                    cu = $urandom_range(0, 3);  cv = $urandom_range(0, 3);
                end
                items_pending.push_back(mk_write(cu, cv, $urandom_range(0, 3), rand_coeff()));
            end
            items_pending.push_back(mk_eval($urandom_range(0, 3), 16'($urandom), 16'($urandom),
                                            2'($urandom), 2'($urandom)));
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_pending.size() > 0 || s_tvalid) @(posedge aclk);
        while (surface_due.size() > 0) @(posedge aclk);
        repeat (1200) @(posedge aclk);

        if (failures == 0) begin
            $display("cosine_series_surface_eval_test: PASS");
        end else begin
            $display("cosine_series_surface_eval_test: FAIL");
        end
        $finish;
    end

endmodule
